[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and gated by an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VDF_ASSERT_IMP(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define VDF_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |=> (cons)) else $error(msg);

`endif

[design/vdf_pkg.sv]
// ----------------------------------------------------------------------------
// vdf_pkg
// Constants, codes and controller/datapath interface types of the voxel
// distance-field ray marcher.
// ----------------------------------------------------------------------------
package vdf_pkg;

	localparam int WORLD_SIZE      = 64;
	localparam int FRAC_BITS       = 10;
	localparam int MAX_MARCH_STEPS = 256;

	localparam int IN_POS_W    = 18;
	localparam int DIR_W       = 16;
	localparam int STEP_W      = 16;
	localparam int COLOR_W     = 8;
	localparam int COORD_OUT_W = 8;
	localparam int PROD_FRAC   = 26;
	localparam int MOVE_SHIFT  = PROD_FRAC - FRAC_BITS;

	localparam int COORD_W  = $clog2(WORLD_SIZE);
	localparam int COORD_W1 = COORD_W + 1;
	localparam logic [COORD_W:0]   WORLD_LIM = COORD_W1'(WORLD_SIZE);
	localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(WORLD_SIZE - 1);

	// position must hold an in-world point plus one full move either way
	localparam int POS_GROW_W = ((COORD_W > 4) ? COORD_W : 4) + FRAC_BITS + 2;
	localparam int POS_W      = (POS_GROW_W > IN_POS_W) ? POS_GROW_W : IN_POS_W;
	localparam int CELL_W     = POS_W - FRAC_BITS;

	localparam int ADDR_W     = 3 * COORD_W;
	localparam int RAM_DEPTH  = 1 << ADDR_W;
	localparam int WORD_W     = STEP_W + COLOR_W;
	localparam int PROD_W     = DIR_W + STEP_W + 1;
	localparam int STEP_CNT_W = $clog2(MAX_MARCH_STEPS + 1);

	typedef enum logic {
		OP_WRITE,
		OP_CAST
	} opcode_t;

	typedef enum logic [1:0] {
		MS_HIT,
		MS_EXIT,
		MS_OUTSIDE,
		MS_CAP
	} march_status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_MUL,
		ST_ADD,
		ST_EXIT,
		ST_OUTSIDE
	} state_t;

	typedef struct packed {
		logic          clear_en;
		logic          store;
		logic          start;
		logic          read_cur;
		logic          mul;
		logic          advance;
		logic          load_res;
		march_status_t res_kind;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic item_cast;
		logic item_in_world;
		logic solid;
		logic cap;
		logic next_in_world;
		logic out_free;
	} stat_t;

endpackage

[design/vdf_ram.sv]
// ----------------------------------------------------------------------------
// vdf_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module vdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/vdf_ctrl.sv]
// ----------------------------------------------------------------------------
// vdf_ctrl
// Sequencer: clearing pass, item intake, read / multiply / add march loop and
// result hand-off.
// ----------------------------------------------------------------------------
module vdf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  vdf_pkg::stat_t stat,
	output vdf_pkg::cmd_t  cmd,
	output logic           item_stall
);
	import vdf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (item_valid && stat.item_cast) begin
					state_d = stat.item_in_world ? ST_READ : ST_OUTSIDE;
				end
			end
			ST_READ: state_d = ST_CHECK;
			ST_CHECK: begin
				if (stat.solid || stat.cap) begin
					if (stat.out_free) state_d = ST_IDLE;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_ADD;
			ST_ADD: state_d = stat.next_in_world ? ST_CHECK : ST_EXIT;
			ST_EXIT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			ST_OUTSIDE: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.res_kind = MS_HIT;
		item_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: cmd.clear_en = 1'b1;
			ST_IDLE: begin
				item_stall = 1'b0;
				cmd.store  = item_valid && !stat.item_cast;
				cmd.start  = item_valid && stat.item_cast;
			end
			ST_READ: cmd.read_cur = 1'b1;
			ST_CHECK: begin
				// solid takes precedence over the step cap
				cmd.load_res = (stat.solid || stat.cap) && stat.out_free;
				cmd.res_kind = stat.solid ? MS_HIT : MS_CAP;
			end
			ST_MUL: cmd.mul = 1'b1;
			ST_ADD: cmd.advance = 1'b1;
			ST_EXIT: begin
				cmd.load_res = stat.out_free;
				cmd.res_kind = MS_EXIT;
			end
			ST_OUTSIDE: begin
				cmd.load_res = stat.out_free;
				cmd.res_kind = MS_OUTSIDE;
			end
			default: begin
				cmd.clear_en = 1'b0;
			end
		endcase
	end

endmodule

[design/vdf_dp.sv]
// ----------------------------------------------------------------------------
// vdf_dp
// Datapath: voxel store, ray position and direction, step products, cell
// address, step count and result register.
// ----------------------------------------------------------------------------
module vdf_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vdf_pkg::cmd_t                       cmd,
	output vdf_pkg::stat_t                      stat,
	input  logic                                opcode,
	input  logic signed [vdf_pkg::IN_POS_W-1:0] pos_x,
	input  logic signed [vdf_pkg::IN_POS_W-1:0] pos_y,
	input  logic signed [vdf_pkg::IN_POS_W-1:0] pos_z,
	input  logic signed [vdf_pkg::DIR_W-1:0]    dir_x,
	input  logic signed [vdf_pkg::DIR_W-1:0]    dir_y,
	input  logic signed [vdf_pkg::DIR_W-1:0]    dir_z,
	input  logic [vdf_pkg::COLOR_W-1:0]         cell_color,
	input  logic [vdf_pkg::STEP_W-1:0]          cell_step,
	input  logic                                result_stall,
	output logic                                result_valid,
	output logic [vdf_pkg::COLOR_W-1:0]         hit_color,
	output logic [vdf_pkg::COORD_OUT_W-1:0]     end_x,
	output logic [vdf_pkg::COORD_OUT_W-1:0]     end_y,
	output logic [vdf_pkg::COORD_OUT_W-1:0]     end_z,
	output logic [1:0]                          march_status
);
	import vdf_pkg::*;

	function automatic logic in_world(input logic signed [CELL_W-1:0] c);
		return (c[CELL_W-1:COORD_W] == '0) && ({1'b0, c[COORD_W-1:0]} < WORLD_LIM);
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [CELL_W-1:0] c);
		logic [COORD_W-1:0] r;
		if (c[CELL_W-1]) r = '0;
		else if (!in_world(c)) r = COORD_MAX;
		else r = c[COORD_W-1:0];
		return r;
	endfunction

	// item position, sign-extended to the working width
	logic signed [POS_W-1:0]  ipx, ipy, ipz;
	logic signed [CELL_W-1:0] icx, icy, icz;
	logic                     item_in_world;
	logic [ADDR_W-1:0]        item_addr;

	logic signed [POS_W-1:0]  px_q, py_q, pz_q;
	logic signed [DIR_W-1:0]  dx_q, dy_q, dz_q;
	logic signed [PROD_W-1:0] mx_q, my_q, mz_q;
	logic [COORD_W-1:0]       cx_q, cy_q, cz_q;
	logic [STEP_CNT_W-1:0]    n_q;
	logic [ADDR_W-1:0]        clr_q;

	logic signed [POS_W-1:0]  nx, ny, nz;
	logic signed [CELL_W-1:0] ncx, ncy, ncz;
	logic [COORD_W-1:0]       nclx, ncly, nclz;
	logic                     next_in_world;

	logic                     ram_we, ram_re;
	logic [ADDR_W-1:0]        ram_addr;
	logic [WORD_W-1:0]        ram_wdata, ram_rdata;
	logic [COLOR_W-1:0]       rd_color;
	logic [STEP_W-1:0]        rd_step;
	logic signed [STEP_W:0]   rd_step_s;

	logic                     res_valid_q;
	logic [COLOR_W-1:0]       res_color_q;
	logic [COORD_OUT_W-1:0]   res_x_q, res_y_q, res_z_q;
	march_status_t            res_status_q;
	logic                     out_free;

	assign ipx = POS_W'(pos_x);
	assign ipy = POS_W'(pos_y);
	assign ipz = POS_W'(pos_z);
	// dropping fraction bits of a two's complement value floors it
	assign icx = ipx[POS_W-1:FRAC_BITS];
	assign icy = ipy[POS_W-1:FRAC_BITS];
	assign icz = ipz[POS_W-1:FRAC_BITS];
	assign item_in_world = in_world(icx) && in_world(icy) && in_world(icz);
	assign item_addr = {icz[COORD_W-1:0], icy[COORD_W-1:0], icx[COORD_W-1:0]};

	assign rd_color  = ram_rdata[COLOR_W-1:0];
	assign rd_step   = ram_rdata[WORD_W-1:COLOR_W];
	assign rd_step_s = $signed({1'b0, rd_step});

	// move = floor(dir * step / 2^MOVE_SHIFT)
	assign nx  = px_q + POS_W'(mx_q >>> MOVE_SHIFT);
	assign ny  = py_q + POS_W'(my_q >>> MOVE_SHIFT);
	assign nz  = pz_q + POS_W'(mz_q >>> MOVE_SHIFT);
	assign ncx = nx[POS_W-1:FRAC_BITS];
	assign ncy = ny[POS_W-1:FRAC_BITS];
	assign ncz = nz[POS_W-1:FRAC_BITS];
	assign next_in_world = in_world(ncx) && in_world(ncy) && in_world(ncz);
	assign nclx = clamp_coord(ncx);
	assign ncly = clamp_coord(ncy);
	assign nclz = clamp_coord(ncz);

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = clr_q;
		ram_wdata = '0;
		priority if (cmd.clear_en) begin
			ram_we = 1'b1;
		end else if (cmd.store) begin
			ram_we    = item_in_world;
			ram_addr  = item_addr;
			ram_wdata = {cell_step, cell_color};
		end else if (cmd.read_cur) begin
			ram_re   = 1'b1;
			ram_addr = {cz_q, cy_q, cx_q};
		end else if (cmd.advance) begin
			// clamped cell is the in-world cell itself when the ray stays inside
			ram_re   = 1'b1;
			ram_addr = {nclz, ncly, nclx};
		end else begin
			ram_re = 1'b0;
		end
	end

	vdf_ram #(
		.WIDTH (WORD_W),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			n_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_en) clr_q <= clr_q + 1'b1;
			if (cmd.start) n_q <= '0;
			else if (cmd.advance) n_q <= n_q + 1'b1;
			if (cmd.load_res) res_valid_q <= 1'b1;
			else if (!result_stall) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= ipx;
			py_q <= ipy;
			pz_q <= ipz;
			dx_q <= dir_x;
			dy_q <= dir_y;
			dz_q <= dir_z;
			cx_q <= icx[COORD_W-1:0];
			cy_q <= icy[COORD_W-1:0];
			cz_q <= icz[COORD_W-1:0];
		end else if (cmd.advance) begin
			px_q <= nx;
			py_q <= ny;
			pz_q <= nz;
			cx_q <= nclx;
			cy_q <= ncly;
			cz_q <= nclz;
		end
		if (cmd.mul) begin
			mx_q <= dx_q * rd_step_s;
			my_q <= dy_q * rd_step_s;
			mz_q <= dz_q * rd_step_s;
		end
		if (cmd.load_res) begin
			res_status_q <= cmd.res_kind;
			res_color_q  <= (cmd.res_kind == MS_HIT || cmd.res_kind == MS_EXIT) ? rd_color : '0;
			res_x_q      <= (cmd.res_kind == MS_OUTSIDE) ? '0 : COORD_OUT_W'(cx_q);
			res_y_q      <= (cmd.res_kind == MS_OUTSIDE) ? '0 : COORD_OUT_W'(cy_q);
			res_z_q      <= (cmd.res_kind == MS_OUTSIDE) ? '0 : COORD_OUT_W'(cz_q);
		end
	end

	assign out_free = !res_valid_q || !result_stall;

	always_comb begin
		stat               = '0;
		stat.clear_last    = &clr_q;
		stat.item_cast     = (opcode == OP_CAST);
		stat.item_in_world = item_in_world;
		stat.solid         = (rd_color != '0);
		stat.cap           = (n_q == STEP_CNT_W'(MAX_MARCH_STEPS));
		stat.next_in_world = next_in_world;
		stat.out_free      = out_free;
	end

	assign result_valid = res_valid_q;
	assign hit_color    = res_color_q;
	assign end_x        = res_x_q;
	assign end_y        = res_y_q;
	assign end_z        = res_z_q;
	assign march_status = res_status_q;

endmodule

[design/voxel_distance_field_ray_march.sv]
// ----------------------------------------------------------------------------
// voxel_distance_field_ray_march
// Voxel store with distance-field ray marching. After reset the block runs a
// clearing pass over the whole store, one cell a cycle (262144 cells for a
// 64-cube world), holding item_stall high until it finishes. A write item
// is stored straight from idle and gives no result. A cast item starting
// outside the world goes to its outside result without marching; any other
// cast makes at most MAX_MARCH_STEPS advances. A finished result also waits
// while a still-stalled earlier result has not left the output register.
// Each advance is one pass round the loop of store read, three parallel
// direction-by-step multiplies and the position add, through the store's
// single port. One item is in flight at a time; a finished result sits in an
// output register, so the next item is taken while that result waits to be
// collected.
// ----------------------------------------------------------------------------
module voxel_distance_field_ray_march (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                opcode,
	input  logic signed [vdf_pkg::IN_POS_W-1:0] pos_x,
	input  logic signed [vdf_pkg::IN_POS_W-1:0] pos_y,
	input  logic signed [vdf_pkg::IN_POS_W-1:0] pos_z,
	input  logic signed [vdf_pkg::DIR_W-1:0]    dir_x,
	input  logic signed [vdf_pkg::DIR_W-1:0]    dir_y,
	input  logic signed [vdf_pkg::DIR_W-1:0]    dir_z,
	input  logic [vdf_pkg::COLOR_W-1:0]         cell_color,
	input  logic [vdf_pkg::STEP_W-1:0]          cell_step,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [vdf_pkg::COLOR_W-1:0]         hit_color,
	output logic [vdf_pkg::COORD_OUT_W-1:0]     end_x,
	output logic [vdf_pkg::COORD_OUT_W-1:0]     end_y,
	output logic [vdf_pkg::COORD_OUT_W-1:0]     end_z,
	output logic [1:0]                          march_status
);
	import vdf_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	vdf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.stat       (stat),
		.cmd        (cmd),
		.item_stall (item_stall)
	);

	vdf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (opcode),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.dir_x        (dir_x),
		.dir_y        (dir_y),
		.dir_z        (dir_z),
		.cell_color   (cell_color),
		.cell_step    (cell_step),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.hit_color    (hit_color),
		.end_x        (end_x),
		.end_y        (end_y),
		.end_z        (end_z),
		.march_status (march_status)
	);

endmodule

[design/vdf_checker.sv]
// ----------------------------------------------------------------------------
// vdf_checker
// Port-level checks on the ray marcher's result channel, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vdf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic [vdf_pkg::COLOR_W-1:0]     hit_color,
	input logic [vdf_pkg::COORD_OUT_W-1:0] end_x,
	input logic [vdf_pkg::COORD_OUT_W-1:0] end_y,
	input logic [vdf_pkg::COORD_OUT_W-1:0] end_z,
	input logic [1:0]                      march_status
);
	import vdf_pkg::*;

	logic [COLOR_W+3*COORD_OUT_W+1:0] res_beat;
	logic                             held;
	logic                             is_outside;
	logic                             is_cap;
	logic                             is_hit;
	logic                             all_zero;
	logic                             end_ok;

	assign res_beat   = {hit_color, end_x, end_y, end_z, march_status};
	assign held       = result_valid && result_stall;
	assign is_outside = result_valid && march_status == MS_OUTSIDE;
	assign is_cap     = result_valid && march_status == MS_CAP;
	assign is_hit     = result_valid && march_status == MS_HIT;
	assign all_zero   = hit_color == '0 && end_x == '0 && end_y == '0 && end_z == '0;
	assign end_ok     = end_x < WORLD_SIZE && end_y < WORLD_SIZE && end_z < WORLD_SIZE;

	// a stalled result beat holds
	`VDF_ASSERT_NEXT(a_hold, clk, arst_n, held, result_valid && $stable(res_beat), "beat moved")

	`VDF_ASSERT_IMP(a_outside_zero, clk, arst_n, is_outside, all_zero, "outside result not zero")

	`VDF_ASSERT_IMP(a_cap_air, clk, arst_n, is_cap, hit_color == '0, "cap result coloured")

	`VDF_ASSERT_IMP(a_hit_solid, clk, arst_n, is_hit, hit_color != '0, "hit reported on air")

	`VDF_ASSERT_IMP(a_end_in_world, clk, arst_n, result_valid, end_ok, "end cell outside world")

endmodule

bind voxel_distance_field_ray_march vdf_checker u_vdf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.hit_color    (hit_color),
	.end_x        (end_x),
	.end_y        (end_y),
	.end_z        (end_z),
	.march_status (march_status)
);

[bench/voxel_distance_field_ray_march_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel_distance_field_ray_march_tb
// Self-checking bench for the voxel ray marcher. It waits out the clearing
// pass after reset, walks a short table of probe beats, then lays random air
// corridors ending in a solid cell, a still air cell or the world edge and
// casts rays down them, mixed with raw random beats. A store and march model
// predicts each result not in the table; both ports idle at random, the
// result side holds off for a long stretch and the item side drains once.
// ----------------------------------------------------------------------------
module voxel_distance_field_ray_march_tb;
	import vdf_pkg::*;

	localparam int ITEM_TARGET = 1300;
	localparam int CALM_FROM   = 200;
	localparam int CALM_TO     = 400;
	localparam int HOLD_AT     = 700;
	localparam int HOLD_CYCLES = 1500;
	localparam int DRAIN_AT    = 1000;
	localparam int DRAIN_WAIT  = 3 * MAX_MARCH_STEPS + 16;
	localparam int QUIET_LIMIT = 3 * RAM_DEPTH;
	localparam longint ONE     = 1 << FRAC_BITS;
	localparam longint DIR_ONE = 16384;

	typedef struct packed {
		opcode_t                     op;
		logic signed [IN_POS_W-1:0] px, py, pz;
		logic signed [DIR_W-1:0]    dx, dy, dz;
		logic [COLOR_W-1:0]         color;
		logic [STEP_W-1:0]          step;
	} voxel_cmd_t;

	typedef struct packed {
		logic [COLOR_W-1:0]     color;
		logic [COORD_OUT_W-1:0] x, y, z;
		march_status_t          status;
	} ray_end_t;

	typedef struct packed {
		voxel_cmd_t cmd;
		logic       typed;
		ray_end_t   want;
	} probe_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       item_valid;
	logic                       item_stall;
	logic                       opcode;
	logic signed [IN_POS_W-1:0] pos_x, pos_y, pos_z;
	logic signed [DIR_W-1:0]    dir_x, dir_y, dir_z;
	logic [COLOR_W-1:0]         cell_color;
	logic [STEP_W-1:0]          cell_step;
	logic                       result_valid;
	logic                       result_stall;
	logic [COLOR_W-1:0]         hit_color;
	logic [COORD_OUT_W-1:0]     end_x, end_y, end_z;
	logic [1:0]                 march_status;

	bit [WORD_W-1:0] voxel_mem [RAM_DEPTH];
	ray_end_t        pending [$];
	ray_end_t        due;
	int              counted, writes_taken, rays_taken, results_seen, fails;
	int              endings [4];

	always #6 clk = ~clk;

	voxel_distance_field_ray_march dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.dir_x        (dir_x),
		.dir_y        (dir_y),
		.dir_z        (dir_z),
		.cell_color   (cell_color),
		.cell_step    (cell_step),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.hit_color    (hit_color),
		.end_x        (end_x),
		.end_y        (end_y),
		.end_z        (end_z),
		.march_status (march_status)
	);

	// ------------------------------------------------------------------
	// store and march model
	// ------------------------------------------------------------------
	function automatic bit world_has(longint x, longint y, longint z);
		return x >= 0 && x < WORLD_SIZE && y >= 0 && y < WORLD_SIZE &&
			z >= 0 && z < WORLD_SIZE;
	endfunction

	function automatic int cell_addr(longint x, longint y, longint z);
		return int'(x + WORLD_SIZE * (y + WORLD_SIZE * z));
	endfunction

	// dir * stride carries 26 fraction bits; floor back to position scale
	function automatic longint advance(longint p, longint d, longint stride);
		return p + ((d * stride) >>> MOVE_SHIFT);
	endfunction

	function automatic ray_end_t ray_end(longint color, longint x, longint y, longint z,
			march_status_t st);
		ray_end_t r;
		r.color  = COLOR_W'(color);
		r.x      = COORD_OUT_W'(x);
		r.y      = COORD_OUT_W'(y);
		r.z      = COORD_OUT_W'(z);
		r.status = st;
		return r;
	endfunction

	function automatic ray_end_t march_ray(voxel_cmd_t c);
		longint          p [3];
		longint          d [3];
		longint          g [3];
		bit [WORD_W-1:0] word;
		p[0] = $signed(c.px);
		p[1] = $signed(c.py);
		p[2] = $signed(c.pz);
		d[0] = $signed(c.dx);
		d[1] = $signed(c.dy);
		d[2] = $signed(c.dz);
		for (int k = 0; k < 3; k++)
			g[k] = p[k] >>> FRAC_BITS;
		if (!world_has(g[0], g[1], g[2]))
			return ray_end(0, 0, 0, 0, MS_OUTSIDE);
		for (int n = 0; n <= MAX_MARCH_STEPS; n++) begin
			word = voxel_mem[cell_addr(g[0], g[1], g[2])];
			if (word[COLOR_W-1:0] != '0)
				return ray_end(word[COLOR_W-1:0], g[0], g[1], g[2], MS_HIT);
			if (n == MAX_MARCH_STEPS)
				return ray_end(0, g[0], g[1], g[2], MS_CAP);
			for (int k = 0; k < 3; k++) begin
				p[k] = advance(p[k], d[k], word[WORD_W-1:COLOR_W]);
				g[k] = p[k] >>> FRAC_BITS;
			end
			if (!world_has(g[0], g[1], g[2])) begin
				for (int k = 0; k < 3; k++)
					g[k] = (g[k] < 0) ? 0 : (g[k] > WORLD_SIZE - 1) ? WORLD_SIZE - 1 : g[k];
				word = voxel_mem[cell_addr(g[0], g[1], g[2])];
				return ray_end(word[COLOR_W-1:0], g[0], g[1], g[2], MS_EXIT);
			end
		end
		return ray_end(0, 0, 0, 0, MS_CAP);
	endfunction

	// bookkeeping for a beat taken by the block
	function automatic void absorb(voxel_cmd_t c, bit typed, ray_end_t want);
		longint x, y, z;
		x = $signed(c.px) >>> FRAC_BITS;
		y = $signed(c.py) >>> FRAC_BITS;
		z = $signed(c.pz) >>> FRAC_BITS;
		if (c.op == OP_WRITE) begin
			if (world_has(x, y, z)) begin
				voxel_mem[cell_addr(x, y, z)] = {c.step, c.color};
				writes_taken++;
				counted++;
			end
		end else begin
			pending.push_back(typed ? want : march_ray(c));
			rays_taken++;
			counted++;
		end
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	// ------------------------------------------------------------------
	// item side
	// ------------------------------------------------------------------
	task automatic send_item(input voxel_cmd_t c, input bit typed, input ray_end_t want);
		while (!(counted >= CALM_FROM && counted < CALM_TO) && $urandom_range(99) < 23) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		opcode     <= c.op;
		pos_x      <= c.px;
		pos_y      <= c.py;
		pos_z      <= c.pz;
		dir_x      <= c.dx;
		dir_y      <= c.dy;
		dir_z      <= c.dz;
		cell_color <= c.color;
		cell_step  <= c.step;
		do
			@(posedge clk);
		while (item_stall);
		absorb(c, typed, want);
	endtask

	function automatic probe_row_t wr(longint x, longint y, longint z, longint color,
			longint stride);
		probe_row_t r;
		r           = '0;
		r.cmd.op    = OP_WRITE;
		r.cmd.px    = IN_POS_W'(x);
		r.cmd.py    = IN_POS_W'(y);
		r.cmd.pz    = IN_POS_W'(z);
		r.cmd.color = COLOR_W'(color);
		r.cmd.step  = STEP_W'(stride);
		return r;
	endfunction

	function automatic probe_row_t ray(longint x, longint y, longint z, longint dx,
			longint dy, longint dz, bit typed, ray_end_t want);
		probe_row_t r;
		r        = '0;
		r.cmd.op = OP_CAST;
		r.cmd.px = IN_POS_W'(x);
		r.cmd.py = IN_POS_W'(y);
		r.cmd.pz = IN_POS_W'(z);
		r.cmd.dx = DIR_W'(dx);
		r.cmd.dy = DIR_W'(dy);
		r.cmd.dz = DIR_W'(dz);
		r.typed  = typed;
		r.want   = want;
		return r;
	endfunction

	// air cells laid along the ray's own path, then a solid stop, a still air cell or the edge
	task automatic lay_corridor();
		probe_row_t         row;
		longint             start [3];
		longint             dir [3];
		longint             at [3];
		int                 hops;
		int                 axis;
		logic [STEP_W-1:0]  stride;
		for (int k = 0; k < 3; k++) begin
			start[k] = $urandom_range((WORLD_SIZE << FRAC_BITS) - 1);
			dir[k]   = ($urandom_range(4) == 0) ? 0 : longint'($urandom_range(32768)) - DIR_ONE;
			at[k]    = start[k];
		end
		if ($urandom_range(4) == 0) begin
			axis = $urandom_range(2);
			for (int k = 0; k < 3; k++)
				dir[k] = 0;
			dir[axis] = $urandom_range(1) ? DIR_ONE : -DIR_ONE;
		end
		hops = $urandom_range(6);
		for (int i = 0; i < hops && world_has(at[0] >>> FRAC_BITS, at[1] >>> FRAC_BITS,
				at[2] >>> FRAC_BITS); i++) begin
			stride = ($urandom_range(39) == 0) ? '0 : STEP_W'($urandom_range(16'hFFFF, 16'h0400));
			row = wr(at[0], at[1], at[2], 0, stride);
			send_item(row.cmd, 1'b0, '0);
			for (int k = 0; k < 3; k++)
				at[k] = advance(at[k], dir[k], stride);
		end
		if (world_has(at[0] >>> FRAC_BITS, at[1] >>> FRAC_BITS, at[2] >>> FRAC_BITS) &&
				$urandom_range(9) != 0) begin
			// now and then a still air cell, which parks the ray until the cap
			if ($urandom_range(15) == 0)
				row = wr(at[0], at[1], at[2], 0, 0);
			else
				row = wr(at[0], at[1], at[2], $urandom_range(255, 1), $urandom_range(16'hFFFF));
			send_item(row.cmd, 1'b0, '0);
		end
		row = ray(start[0], start[1], start[2], dir[0], dir[1], dir[2], 1'b0, '0);
		row.cmd.color = COLOR_W'($urandom);
		row.cmd.step  = STEP_W'($urandom);
		send_item(row.cmd, 1'b0, '0);
	endtask

	initial begin : stimulus
		probe_row_t probes [$];
		voxel_cmd_t c;
		bit         drained;
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		opcode     <= OP_WRITE;
		pos_x      <= '0;
		pos_y      <= '0;
		pos_z      <= '0;
		dir_x      <= '0;
		dir_y      <= '0;
		dir_z      <= '0;
		cell_color <= '0;
		cell_step  <= '0;
		drained    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// cleared store: air with no stride everywhere, so a ray parks until the cap
		probes.push_back(ray(0, 0, 0, 0, 0, 0, 1'b1, ray_end(0, 0, 0, 0, MS_CAP)));
		probes.push_back(ray(-1, 0, 0, DIR_ONE, 0, 0, 1'b1, ray_end(0, 0, 0, 0, MS_OUTSIDE)));
		probes.push_back(ray(131071, 0, 0, 0, 0, 0, 1'b1, ray_end(0, 0, 0, 0, MS_OUTSIDE)));
		probes.push_back(ray(0, -131072, 0, 0, -DIR_ONE, 0, 1'b1,
			ray_end(0, 0, 0, 0, MS_OUTSIDE)));
		probes.push_back(ray(0, 0, WORLD_SIZE * ONE, 0, 0, DIR_ONE, 1'b1,
			ray_end(0, 0, 0, 0, MS_OUTSIDE)));
		// off-world writes must not alias onto a real cell
		probes.push_back(wr(WORLD_SIZE * ONE, 0, 0, 200, 16'h1000));
		probes.push_back(wr(0, -1, 0, 200, 16'h1000));
		probes.push_back(ray(0, ONE, 0, 0, 0, 0, 1'b1, ray_end(0, 0, 1, 0, MS_CAP)));
		probes.push_back(wr(65535, 65535, 65535, 255, 16'hFFFF));
		probes.push_back(ray(65535, 65535, 65535, DIR_ONE, DIR_ONE, DIR_ONE, 1'b1,
			ray_end(255, 63, 63, 63, MS_HIT)));
		// edge exits; the clamped cell's colour is reported even when solid
		probes.push_back(wr(62 * ONE, 5 * ONE, 5 * ONE, 0, 16'hFFFF));
		probes.push_back(wr(63 * ONE, 5 * ONE, 5 * ONE, 9, 0));
		probes.push_back(ray(62 * ONE + 512, 5 * ONE, 5 * ONE, DIR_ONE, 0, 0, 1'b0, '0));
		probes.push_back(wr(0, ONE, ONE, 0, 16'h1000));
		probes.push_back(ray(512, ONE + 512, ONE + 512, -DIR_ONE, 0, 0, 1'b0, '0));
		// short corridor; the tiny negative y move floors into the row below
		probes.push_back(wr(10 * ONE, 10 * ONE, 10 * ONE, 0, 16'h1000));
		probes.push_back(wr(11 * ONE, 10 * ONE, 10 * ONE, 0, 16'h1000));
		probes.push_back(wr(12 * ONE, 10 * ONE, 10 * ONE, 7, 16'h0001));
		probes.push_back(wr(12 * ONE, 9 * ONE, 10 * ONE, 3, 0));
		probes.push_back(ray(10 * ONE, 10 * ONE, 10 * ONE, DIR_ONE, 0, 0, 1'b0, '0));
		probes.push_back(ray(11 * ONE, 10 * ONE, 10 * ONE, DIR_ONE, -1, 0, 1'b0, '0));
		probes.push_back(wr(20 * ONE, 20 * ONE, 0, 0, 16'hFFFF));
		probes.push_back(ray(20 * ONE, 20 * ONE, 0, 0, 0, -DIR_ONE, 1'b0, '0));
		probes.push_back(wr(30 * ONE, 62 * ONE, 30 * ONE, 0, 16'hFFFF));
		probes.push_back(ray(30 * ONE, 62 * ONE, 30 * ONE, 0, DIR_ONE, 0, 1'b0, '0));
		foreach (probes[i])
			send_item(probes[i].cmd, probes[i].typed, probes[i].want);

		while (counted < ITEM_TARGET) begin
			if (!drained && counted >= DRAIN_AT) begin
				drained = 1'b1;
				item_valid <= 1'b0;
				@(posedge clk);
				while (pending.size() != 0)
					@(posedge clk);
			end
			if ($urandom_range(99) < 85) begin
				lay_corridor();
			end else begin
				c.op    = $urandom_range(1) ? OP_CAST : OP_WRITE;
				c.px    = IN_POS_W'($urandom);
				c.py    = IN_POS_W'($urandom);
				c.pz    = IN_POS_W'($urandom);
				if ($urandom_range(2) == 0) begin
					c.px = IN_POS_W'($urandom_range((WORLD_SIZE << FRAC_BITS) - 1));
					c.py = IN_POS_W'($urandom_range((WORLD_SIZE << FRAC_BITS) - 1));
					c.pz = IN_POS_W'($urandom_range((WORLD_SIZE << FRAC_BITS) - 1));
				end
				c.dx    = DIR_W'(longint'($urandom_range(32768)) - DIR_ONE);
				c.dy    = DIR_W'(longint'($urandom_range(32768)) - DIR_ONE);
				c.dz    = DIR_W'(longint'($urandom_range(32768)) - DIR_ONE);
				c.color = COLOR_W'($urandom);
				c.step  = STEP_W'($urandom);
				send_item(c, 1'b0, '0);
			end
		end
		item_valid <= 1'b0;

		while (pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("%0d beats taken: %0d cell writes, %0d rays; %0d results checked",
			counted, writes_taken, rays_taken, results_seen);
		$display("ray endings: %0d solid, %0d left world, %0d outside start, %0d step cap",
			endings[MS_HIT], endings[MS_EXIT], endings[MS_OUTSIDE], endings[MS_CAP]);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------
	initial begin : result_pacing
		bit held;
		held = 1'b0;
		forever begin
			if (!held && counted >= HOLD_AT) begin
				// long hold so the output register fills and the input backs up
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				result_stall <= (counted >= CALM_FROM && counted < CALM_TO) ? 1'b0 :
					($urandom_range(99) < 23);
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending.size() == 0) begin
				$error("result beat with no ray outstanding");
				fails++;
			end else begin
				due = pending.pop_front();
				check_field("hit_color", due.color, hit_color);
				check_field("end_x", due.x, end_x);
				check_field("end_y", due.y, end_y);
				check_field("end_z", due.z, end_z);
				check_field("march_status", due.status, march_status);
			end
			endings[march_status]++;
			results_seen++;
		end
	end

	// covers the clearing pass after reset, several times over
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/vdf_pkg.sv
design/vdf_ram.sv
design/vdf_ctrl.sv
design/vdf_dp.sv
design/voxel_distance_field_ray_march.sv
design/vdf_checker.sv
bench/voxel_distance_field_ray_march_tb.sv
